// ===== hw/rtl/mld_pkg.sv =====
// Shared types and constants for the magic/length deframer.
// No dependencies; imported by the parser, the output buffer, the top and the testbench.
package mld_pkg;

	localparam logic [7:0]  SYNC_FIRST      = 8'h94;
	localparam logic [7:0]  SYNC_SECOND     = 8'hC3;
	localparam logic [15:0] MAX_PAYLOAD_RST = 16'd512;

	// One outgoing word as produced by the parser.
	typedef struct packed {
		logic [7:0] payload_byte;
		logic       frame_first;
		logic       frame_last;
		logic       frame_empty;
	} mld_result_t;

endpackage

// ===== hw/rtl/mld_parser.sv =====
// Header parser: sync hunt, length capture and payload counting.
// Depends on mld_pkg for sync constants and the result struct.
module mld_parser import mld_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        accept,
	input  logic [7:0]  rx_byte,
	input  logic [15:0] max_payload,
	output logic        res_valid,
	output mld_result_t res
);

	typedef enum logic [2:0] {
		PH_HUNT      = 3'd0,
		PH_GOT_FIRST = 3'd1,
		PH_LEN_HIGH  = 3'd2,
		PH_LEN_LOW   = 3'd3,
		PH_PAY_FIRST = 3'd4,
		PH_PAY_REST  = 3'd5
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [7:0]  len_high_q, len_high_d;
	logic [15:0] left_q, left_d;
	logic [15:0] len;
	logic        emit;

	assign len = {len_high_q, rx_byte};

	always_comb begin
		phase_d    = phase_q;
		len_high_d = len_high_q;
		left_d     = left_q;
		emit       = 1'b0;
		res        = '0;
		unique case (phase_q)
			PH_GOT_FIRST: begin
				if (rx_byte == SYNC_SECOND) begin
					phase_d = PH_LEN_HIGH;
				end else begin
					phase_d = (rx_byte == SYNC_FIRST) ? PH_GOT_FIRST : PH_HUNT;
				end
			end
			PH_LEN_HIGH: begin
				len_high_d = rx_byte;
				phase_d    = PH_LEN_LOW;
			end
			PH_LEN_LOW: begin
				if (len > max_payload) begin
					// false sync: rescan the two length bytes
					left_d = '0;
					if (len_high_q == SYNC_FIRST && rx_byte == SYNC_SECOND) begin
						phase_d = PH_LEN_HIGH;
					end else begin
						phase_d = (rx_byte == SYNC_FIRST) ? PH_GOT_FIRST : PH_HUNT;
					end
				end else if (len == '0) begin
					left_d            = '0;
					phase_d           = PH_HUNT;
					emit              = 1'b1;
					res.frame_first   = 1'b1;
					res.frame_last    = 1'b1;
					res.frame_empty   = 1'b1;
				end else begin
					left_d  = len;
					phase_d = PH_PAY_FIRST;
				end
			end
			PH_PAY_FIRST, PH_PAY_REST: begin
				left_d           = left_q - 16'd1;
				emit             = 1'b1;
				res.payload_byte = rx_byte;
				res.frame_first  = (phase_q == PH_PAY_FIRST);
				res.frame_last   = (left_q == 16'd1);
				phase_d          = (left_q == 16'd1) ? PH_HUNT : PH_PAY_REST;
			end
			default: begin
				phase_d = (rx_byte == SYNC_FIRST) ? PH_GOT_FIRST : PH_HUNT;
			end
		endcase
	end

	assign res_valid = accept & emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HUNT;
			len_high_q <= '0;
			left_q     <= '0;
		end else if (accept) begin
			phase_q    <= phase_d;
			len_high_q <= len_high_d;
			left_q     <= left_d;
		end
	end

endmodule

// ===== hw/rtl/mld_outbuf.sv =====
// Output register with a one-word skid stage.
// Depends on mld_pkg for the result struct.
module mld_outbuf import mld_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  mld_result_t in_word,
	output logic        in_ready,
	output logic        out_valid,
	input  logic        out_ready,
	output mld_result_t out_word
);

	logic        out_valid_q, skid_valid_q;
	mld_result_t out_q, skid_q;

	assign in_ready  = ~skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_word  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || out_ready) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= in_valid;
			end
		end else if (in_valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		if (!out_valid_q || out_ready) begin
			out_q <= skid_valid_q ? skid_q : in_word;
		end
		if (out_valid_q && !out_ready && in_valid && !skid_valid_q) begin
			skid_q <= in_word;
		end
	end

endmodule

// ===== hw/rtl/magic_length_deframer.sv =====
// Each payload byte or empty-frame marker is registered to m_*, via the skid word on a stall.
// Throughput: one input word per cycle; s_tready drops only while the skid word is held.
// The skid word fills only when a result arrives while the output word is stalled.
// Reset (arst_n low): parser returns to sync hunt, max_payload returns to 512, both output
// and skid words are emptied. Depends on mld_pkg, mld_parser and mld_outbuf.
module magic_length_deframer import mld_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// configuration: max_payload register
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	// output stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [7:0] payload_byte
	output logic        m_tlast,   // frame_last
	output logic [1:0]  m_tuser    // [0] frame_first, [1] frame_empty
);

	logic [15:0] max_payload_q;
	logic        accept;
	logic        res_valid;
	mld_result_t res;
	mld_result_t out_word;

	// Hold the maximum length; the user must write it only while the block is idle (not enforced here).
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_payload_q <= MAX_PAYLOAD_RST;
		end else if (cfg_we) begin
			max_payload_q <= cfg_wdata;
		end
	end

	// Advance the parser on every accepted input word.
	assign accept = s_tvalid & s_tready;

	mld_parser u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.rx_byte     (s_tdata),
		.max_payload (max_payload_q),
		.res_valid   (res_valid),
		.res         (res)
	);

	// Register results; the skid word absorbs one result while m_tready is low.
	mld_outbuf u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (res_valid),
		.in_word   (res),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_word  (out_word)
	);

	assign m_tdata = out_word.payload_byte;
	assign m_tlast = out_word.frame_last;
	assign m_tuser = {out_word.frame_empty, out_word.frame_first};

endmodule

// ===== hw/rtl/mld_checker.sv =====
// Port-level checks for magic_length_deframer, attached by bind.
// No package dependencies.
module mld_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_tready,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic       m_tlast,
	input logic [1:0] m_tuser
);

	// stalled output word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
			&& $stable(m_tuser))
		else $error("output word changed while stalled");

	// empty marker is a whole frame with zero data
	a_empty_frame: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> m_tuser[0] && m_tlast && (m_tdata == 8'd0))
		else $error("malformed empty-frame marker");

	// input backpressure only follows an output stall
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> $past(m_tvalid && !m_tready))
		else $error("s_tready low without output stall");

endmodule

bind magic_length_deframer mld_checker u_mld_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast),
	.m_tuser  (m_tuser)
);

// ===== tb/sv/magic_length_deframer_tb.sv =====
// Self-checking testbench for magic_length_deframer: byte stimulus in, framed payload words out.
// Holds its own frame-parser predictor in a scoreboard class; depends on mld_pkg and the DUT.
module magic_length_deframer_tb import mld_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 2000;  // cycles with no word moving on either side
	localparam int LONG_HOLD      = 300;   // receiver back-pressure stretch

	// Parser phases of the predictor.
	typedef enum logic [2:0] {
		ST_HUNT,
		ST_SYNC1,
		ST_LEN_HI,
		ST_LEN_LO,
		ST_PAY_FIRST,
		ST_PAY_REST
	} parse_state_t;

	// Predicts the framed output words and checks the DUT against them.
	class deframe_scoreboard;
		mld_result_t  expected_q[$];
		logic [15:0]  max_len;
		parse_state_t state;
		logic [7:0]   len_hi;
		logic [15:0]  left;
		int           errors;

		function new();
			max_len = MAX_PAYLOAD_RST;
			state   = ST_HUNT;
			len_hi  = 8'h00;
			left    = 16'h0000;
			errors  = 0;
		endfunction

		function void set_max(logic [15:0] v);
			max_len = v;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		// Where a byte outside a header leaves the hunt.
		function parse_state_t after_hunt(logic [7:0] b);
			if (b == SYNC_FIRST)
				return ST_SYNC1;
			return ST_HUNT;
		endfunction

		// Advance the parser by one accepted byte; queue the word it produces, if any.
		function void note_byte(logic [7:0] b);
			logic [15:0] len;
			mld_result_t r;
			case (state)
				ST_SYNC1: begin
					if (b == SYNC_SECOND)
						state = ST_LEN_HI;
					else
						state = after_hunt(b);
				end
				ST_LEN_HI: begin
					len_hi = b;
					state  = ST_LEN_LO;
				end
				ST_LEN_LO: begin
					len = {len_hi, b};
					if (len > max_len) begin
						// false sync: rescan both length bytes
						if (len_hi == SYNC_FIRST && b == SYNC_SECOND)
							state = ST_LEN_HI;
						else
							state = after_hunt(b);
						left = 16'h0000;
					end else if (len == 16'h0000) begin
						state = ST_HUNT;
						left  = 16'h0000;
						r.payload_byte = 8'h00;
						r.frame_first  = 1'b1;
						r.frame_last   = 1'b1;
						r.frame_empty  = 1'b1;
						expected_q.push_back(r);
					end else begin
						left  = len;
						state = ST_PAY_FIRST;
					end
				end
				ST_PAY_FIRST, ST_PAY_REST: begin
					left = left - 16'd1;
					r.payload_byte = b;
					r.frame_first  = (state == ST_PAY_FIRST);
					r.frame_last   = (left == 16'h0000);
					r.frame_empty  = 1'b0;
					if (r.frame_last)
						state = ST_HUNT;
					else
						state = ST_PAY_REST;
					expected_q.push_back(r);
				end
				default: state = after_hunt(b);
			endcase
		endfunction

		task report_mismatch(string msg);
			$display("MISMATCH: %s", msg);
			errors++;
		endtask

		// Compare one accepted output word with the oldest expectation.
		task check_word(mld_result_t got);
			mld_result_t want;
			if (expected_q.size() == 0) begin
				report_mismatch($sformatf("unexpected word data=%0h first=%0b last=%0b empty=%0b",
					got.payload_byte, got.frame_first, got.frame_last, got.frame_empty));
				return;
			end
			want = expected_q.pop_front();
			if (got.payload_byte !== want.payload_byte)
				report_mismatch($sformatf("payload_byte got %0h want %0h",
					got.payload_byte, want.payload_byte));
			if (got.frame_first !== want.frame_first)
				report_mismatch($sformatf("frame_first got %0b want %0b",
					got.frame_first, want.frame_first));
			if (got.frame_last !== want.frame_last)
				report_mismatch($sformatf("frame_last got %0b want %0b",
					got.frame_last, want.frame_last));
			if (got.frame_empty !== want.frame_empty)
				report_mismatch($sformatf("frame_empty got %0b want %0b",
					got.frame_empty, want.frame_empty));
		endtask
	endclass

	// DUT inputs start at known values.
	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        cfg_we    = 1'b0;
	logic [15:0] cfg_wdata = 16'h0000;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata   = 8'h00;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [7:0]  m_tdata;
	logic        m_tlast;
	logic [1:0]  m_tuser;

	deframe_scoreboard sb = new();

	bit idle_on     = 1'b1;   // random gaps and stalls on both sides
	bit squeeze_req = 1'b0;   // ask the receiver for one long hold-off
	int cur_max     = int'(MAX_PAYLOAD_RST);
	int bytes_sent  = 0;
	int quiet       = 0;

	magic_length_deframer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser)
	);

	always #5 clk = ~clk;

	// Sample outputs at the rising edge; watch for a stuck handshake.
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				sb.check_word(mld_result_t'{m_tdata, m_tuser[0], m_tlast, m_tuser[1]});
			if ((m_tvalid && m_tready) || (s_tvalid && s_tready)) begin
				quiet = 0;
			end else begin
				quiet++;
				if (quiet >= WATCHDOG_LIMIT) begin
					$display("Simulation FAILED");
					$finish;
				end
			end
		end
	end

	// Receiver: ready most cycles, stall in random bursts, and hold off once for a long stretch
	// so the output and skid words fill up and the DUT drops s_tready.
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (squeeze_req) begin
				squeeze_req = 1'b0;
				m_tready <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
				m_tready <= 1'b1;
			end else if (idle_on && $urandom_range(0, 4) == 0) begin
				n = $urandom_range(1, 14);
				m_tready <= 1'b0;
				repeat (n - 1) @(negedge clk);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Offer one byte, hold it until accepted, then step to the next falling edge.
	// Valid is left high on return; the next call either replaces the word or drops valid.
	task automatic send_byte(input logic [7:0] b);
		int gap;
		if (idle_on && $urandom_range(0, 6) == 0) begin
			gap = $urandom_range(1, 14);
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		do @(posedge clk); while (!s_tready);
		sb.note_byte(b);
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic send_header(input logic [15:0] len);
		send_byte(SYNC_FIRST);
		send_byte(SYNC_SECOND);
		send_byte(len[15:8]);
		send_byte(len[7:0]);
	endtask

	// Drop valid, drain every expected word, then let the pipeline go quiet.
	task automatic settle();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (3) @(negedge clk);
	endtask

	task automatic write_max(input logic [15:0] v);
		settle();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.set_max(v);
		cur_max = int'(v);
	endtask

	// One random burst: mostly well-formed frames, some false syncs, noise and cut-off headers.
	task automatic random_burst();
		int kind;
		int pick;
		int len;
		int lim;
		int n;
		logic [15:0] hdr;
		kind = $urandom_range(0, 99);
		if (kind < 70) begin
			pick = $urandom_range(0, 99);
			lim  = (cur_max < 24) ? cur_max : 24;
			if (cur_max == 0 || pick < 12)
				len = 0;
			else if (pick < 20 && cur_max <= 600)
				len = cur_max;
			else
				len = $urandom_range(1, lim);
			send_header(len[15:0]);
			for (int i = 0; i < len; i++)
				send_byte(8'($urandom_range(0, 255)));
		end else if (kind < 82 && cur_max != 16'hFFFF) begin
			// oversized claim: rescan of the length bytes
			pick = $urandom_range(0, 2);
			if (pick == 0 && {SYNC_FIRST, SYNC_SECOND} > cur_max)
				hdr = {SYNC_FIRST, SYNC_SECOND};
			else if (pick == 1 && cur_max[15:8] != 8'hFF)
				hdr = {8'($urandom_range(cur_max[15:8] + 1, 255)), SYNC_FIRST};
			else
				hdr = 16'($urandom_range(cur_max + 1, 65535));
			send_header(hdr);
		end else if (kind < 94) begin
			// noise biased toward the sync bytes
			n = $urandom_range(1, 6);
			repeat (n) begin
				pick = $urandom_range(0, 3);
				if (pick == 0)
					send_byte(SYNC_FIRST);
				else if (pick == 1)
					send_byte(SYNC_SECOND);
				else
					send_byte(8'($urandom_range(0, 255)));
			end
		end else begin
			// header cut short
			send_byte(SYNC_FIRST);
			if ($urandom_range(0, 1)) begin
				send_byte(SYNC_SECOND);
				send_byte(8'($urandom_range(0, 255)));
			end else begin
				send_byte(8'($urandom_range(0, 255)));
			end
		end
	endtask

	task automatic random_phase(input int count);
		int target;
		target = bytes_sent + count;
		while (bytes_sent < target)
			random_burst();
	endtask

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part, reset limit of 512 first.
		// Repeated first sync byte still syncs, then a zero length gives the empty marker.
		send_byte(SYNC_FIRST);
		send_header(16'h0000);
		// One past the limit: false sync, low byte is not a sync byte, so back to hunting.
		send_header(16'h0201);

		write_max(16'd3);
		// Length equal to the limit is accepted; payload at both byte extremes.
		send_header(16'd3);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'h5A);
		// Oversized length that is itself a sync word: next byte is a length high byte.
		send_header({SYNC_FIRST, SYNC_SECOND});
		send_byte(8'h00);
		send_byte(8'h01);
		send_byte(8'hA5);
		// Oversized length ending in a lone first sync byte.
		send_header({8'h00, SYNC_FIRST});
		send_byte(SYNC_SECOND);
		send_byte(8'h00);
		send_byte(8'h00);

		// Random part over several limits, the extremes among them.
		write_max(16'd0);
		random_phase(250);
		write_max(16'hFFFF);
		random_phase(300);

		write_max(16'd512);
		// Back-pressure: receiver holds off while a long frame keeps coming.
		squeeze_req = 1'b1;
		send_header(16'd80);
		repeat (80) send_byte(8'($urandom_range(0, 255)));
		random_phase(350);

		write_max(16'($urandom_range(1, 40)));
		random_phase(300);
		write_max(16'd1);
		random_phase(200);

		// Last part runs at full rate on both sides.
		write_max(16'($urandom_range(41, 600)));
		idle_on = 1'b0;
		random_phase(300);

		settle();
		if (sb.errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/mld_pkg.sv
hw/rtl/mld_parser.sv
hw/rtl/mld_outbuf.sv
hw/rtl/magic_length_deframer.sv
hw/rtl/mld_checker.sv
tb/sv/magic_length_deframer_tb.sv
